@@ design/dfwr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfwr_pkg
// Shared sizes, command and status codes and address helper for the
// deduplicating queue with removal.
// ----------------------------------------------------------------------------
package dfwr_pkg;

   localparam int DEPTH    = 64;
   localparam int ID_WIDTH = 16;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 3;

   localparam int RSP_USED_W  = ID_WIDTH + STAT_W + 1 + CNT_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   localparam logic [CMD_W-1:0] CMD_ENQ        = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENQ_ABSENT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEQ        = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUP       = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

   // logical queue position -> physical ring address
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  idx);
      logic [ADDR_W:0] sum;
      sum = (ADDR_W + 1)'(head) + (ADDR_W + 1)'(idx);
      if (sum >= (ADDR_W + 1)'(DEPTH)) begin
         sum = sum - (ADDR_W + 1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

@@ design/dfwr_ram.sv @@
// ----------------------------------------------------------------------------
// dfwr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module dfwr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dedup_fifo_with_remove.sv @@
// ----------------------------------------------------------------------------
// dedup_fifo_with_remove
// Bounded FIFO of identifiers with enqueue, enqueue-if-absent, dequeue and
// remove-by-value, held in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: one request per handshake, req_tuser = command, req_tdata = id.
//   rsp_*: exactly one response per request, in order, from an output
//   register, so a new request is taken while a response still waits.
//   Enqueue-if-absent and remove scan the RAM, reading one entry per cycle;
//   removal closes up the later entries in the same pass.
//   Enqueue-if-absent stops the scan at the first match.
//   One request is in work at a time; req_tready is high only while idle.
//   Reset: queue empty, no memory clearing pass; ready the cycle after.
//   A stalled receiver holds the response; the next result waits in the core
//   until the output register frees.
// ----------------------------------------------------------------------------
module dedup_fifo_with_remove (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dfwr_pkg::ID_WIDTH-1:0]       req_tdata,  // item_id
   input  logic [dfwr_pkg::CMD_W-1:0]          req_tuser,  // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // item_out, status, is_empty, entry_count, zero pad
   output logic [dfwr_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DEQ  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam int AW = dfwr_pkg::ADDR_W;
   localparam int CW = dfwr_pkg::CNT_W;
   localparam int IW = dfwr_pkg::ID_WIDTH;
   localparam int SW = dfwr_pkg::STAT_W;

   logic [1:0]                  state_ff, state_in;
   logic [dfwr_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [IW-1:0]               id_ff, id_in;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               rd_idx_ff, rd_idx_in;
   logic [CW-1:0]               ridx_ff, ridx_in;
   logic                        rvalid_ff, rvalid_in;
   logic                        found_ff, found_in;
   logic [IW-1:0]               res_item_ff, res_item_in;
   logic [SW-1:0]               res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]               rsp_item_ff, rsp_item_in;
   logic [SW-1:0]               rsp_status_ff, rsp_status_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   logic [CW-1:0]               rsp_count_ff, rsp_count_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [IW-1:0] ram_wdata, ram_rdata;

   logic req_fire, full, stop, scan_end;

   dfwr_ram #(
      .WIDTH (IW),
      .DEPTH (dfwr_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(dfwr_pkg::DEPTH));
   assign stop       = (cmd_ff == dfwr_pkg::CMD_ENQ_ABSENT) && found_ff;
   assign scan_end   = stop || ((rd_idx_ff == count_ff) && !rvalid_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      ridx_in       = ridx_ff;
      rvalid_in     = 1'b0;
      found_in      = found_ff;
      res_item_in   = res_item_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_tuser;
               id_in         = req_tdata;
               found_in      = 1'b0;
               rd_idx_in     = '0;
               res_item_in   = '0;
               res_status_in = dfwr_pkg::ST_OK;
               state_in      = S_DONE;
               if (req_tuser == dfwr_pkg::CMD_ENQ) begin
                  if (full) begin
                     res_status_in = dfwr_pkg::ST_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = dfwr_pkg::phys_addr(head_ff, count_ff);
                     ram_wdata = req_tdata;
                     count_in  = count_ff + CW'(1);
                  end
               end else if (req_tuser == dfwr_pkg::CMD_DEQ) begin
                  if (count_ff == '0) begin
                     res_status_in = dfwr_pkg::ST_EMPTY;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = head_ff;
                     state_in  = S_DEQ;
                  end
               end else if (count_ff != '0) begin
                  state_in = S_SCAN;
               end else if (req_tuser == dfwr_pkg::CMD_REMOVE) begin
                  res_status_in = dfwr_pkg::ST_NOT_FOUND;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = dfwr_pkg::phys_addr(head_ff, count_ff);
                  ram_wdata = req_tdata;
                  count_in  = count_ff + CW'(1);
               end
            end
         end
         S_DEQ: begin
            res_item_in = ram_rdata;
            head_in     = (head_ff == AW'(dfwr_pkg::DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in    = count_ff - CW'(1);
            state_in    = S_DONE;
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_DONE;
               if (cmd_ff == dfwr_pkg::CMD_REMOVE) begin
                  if (found_ff) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     res_status_in = dfwr_pkg::ST_NOT_FOUND;
                  end
               end else if (found_ff) begin
                  res_status_in = dfwr_pkg::ST_DUP;
               end else if (full) begin
                  res_status_in = dfwr_pkg::ST_FULL;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = dfwr_pkg::phys_addr(head_ff, count_ff);
                  ram_wdata = id_ff;
                  count_in  = count_ff + CW'(1);
               end
            end else begin
               if (rd_idx_ff != count_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = dfwr_pkg::phys_addr(head_ff, rd_idx_ff);
                  rd_idx_in = rd_idx_ff + CW'(1);
                  rvalid_in = 1'b1;
                  ridx_in   = rd_idx_ff;
               end
               if (rvalid_ff) begin
                  if (found_ff) begin
                     // close up: entry k moves to k-1
                     ram_we    = 1'b1;
                     ram_waddr = dfwr_pkg::phys_addr(head_ff, ridx_ff - CW'(1));
                     ram_wdata = ram_rdata;
                  end else if (ram_rdata == id_ff) begin
                     found_in = 1'b1;
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = res_item_ff;
               rsp_status_in = res_status_ff;
               rsp_empty_in  = (count_ff == '0);
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rvalid_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rvalid_ff    <= rvalid_in;
         found_ff     <= found_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      ridx_ff       <= ridx_in;
      res_item_ff   <= res_item_in;
      res_status_ff <= res_status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{dfwr_pkg::RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_empty_ff,
                        rsp_status_ff, rsp_item_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(dfwr_pkg::DEPTH))
      else $error("occupancy above depth");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rvalid_ff)
      else $error("scan read still in flight while idle");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re |-> ram_waddr != ram_raddr)
      else $error("read and write hit the same entry");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEQ |=> count_ff == $past(count_ff) - CW'(1))
      else $error("dequeue did not decrement occupancy");

   a_done_next: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished result not loaded into output register");

endmodule
